// ----- rtl/core/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the utf-8 to utf-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // most utf-16 units a single input byte can cause
  localparam int MaxUnits   = 5;
  // continuation payloads kept for a possible flush
  localparam int PendDepth  = 5;

  localparam logic [15:0] SurrHi    = 16'hD800;
  localparam logic [15:0] SurrLo    = 16'hDC00;
  localparam logic [30:0] BmpMax    = 31'h0000FFFF;
  localparam logic [31:0] SuppBase  = 32'h00010000;
  localparam logic [7:0]  ContMark  = 8'h80;

  typedef logic [15:0] unit_t;
  typedef logic [2:0]  ucount_t;

  // one queue entry: every unit caused by one accepted byte
  typedef struct packed {
    unit_t [MaxUnits-1:0] units;
    ucount_t              count;
  } job_t;

endpackage

// ----- rtl/core/u8u16_if.sv -----
// ----------------------------------------------------------------------------
// u8u16 stream interfaces
// Valid/ready channels for the byte input and the unit output.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_out;
  logic        last_unit;

  modport source (output valid, output unit_out, output last_unit, input ready);
  modport sink   (input valid, input unit_out, input last_unit, output ready);
endinterface

// ----- rtl/core/utf8_to_utf16_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Lenient utf-8 to utf-16 transcoder with valid/ready byte and unit channels.
// ----------------------------------------------------------------------------
// usage:
//   in_if carries one utf-8 byte per transfer plus end_of_stream on the last
//   byte; out_if carries one utf-16 unit per transfer, last_unit set on the
//   final unit that a byte causes. a byte that only opens or extends a
//   sequence gives no unit unless end_of_stream is set.
//   the front decodes a byte in the cycle it is taken and writes its whole
//   unit list (up to five units) into a QUEUE_DEPTH-entry queue; the back
//   loads it once the previous list is sent and presents the first unit;
//   it then gives one unit per cycle while out_if.ready is high.
//   throughput: one byte per cycle while each byte gives at most one unit
//   and out_if.ready is high; a byte with several units holds the output
//   side until all are sent, and the front takes bytes until the queue fills.
//   reset (rst_n low, synchronous) closes any open sequence and empties the
//   queue. when out_if.ready is low the current unit holds, the queue fills,
//   and in_if.ready drops once it is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if.sink    in_if,
  u8u16_out_if.source out_if
);

  // front to queue
  logic            q_push;
  logic            q_can_push;
  u8u16_pkg::job_t q_push_job;

  // queue to back
  logic            q_pop;
  logic            q_can_pop;
  u8u16_pkg::job_t q_pop_job;

  // byte intake, sequence tracking and unit list build
  u8u16_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_ready (q_can_push),
    .q_push  (q_push),
    .q_job   (q_push_job)
  );

  // decouples intake from output stalls
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .can_push (q_can_push),
    .pop      (q_pop),
    .can_pop  (q_can_pop),
    .pop_job  (q_pop_job)
  );

  // one unit per output transfer
  u8u16_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_can_pop),
    .q_job   (q_pop_job),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

// ----- rtl/core/u8u16_front.sv -----
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, tracks the open sequence and builds the unit list per byte.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic              clk,
  input  logic              rst_n,
  u8u16_in_if.sink          in_if,
  input  logic              q_ready,
  output logic              q_push,
  output u8u16_pkg::job_t   q_job
);

  logic [30:0] acc_r, acc_nxt;
  logic [2:0]  need_r, need_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [u8u16_pkg::PendDepth-1:0][5:0] pend_r, pend_nxt;

  logic [7:0]  b;
  logic        is_cont;
  logic [30:0] acc_ext;
  logic [31:0] diff;
  u8u16_pkg::unit_t [u8u16_pkg::MaxUnits-1:0] units;
  logic [2:0]  n;
  logic        xfer;

  assign b       = in_if.in_byte;
  assign is_cont = (b[7:6] == 2'b10);
  assign acc_ext = {acc_r[24:0], b[5:0]};
  assign diff    = {1'b0, acc_ext} - u8u16_pkg::SuppBase;

  assign in_if.ready = q_ready;
  assign xfer        = in_if.valid && q_ready;

  always_comb begin
    acc_nxt  = acc_r;
    need_nxt = need_r;
    seen_nxt = seen_r;
    pend_nxt = pend_r;
    units    = '0;
    n        = '0;

    if (need_r != 3'd0 && is_cont) begin
      acc_nxt = acc_ext;
      if ({1'b0, seen_r} + 4'd1 >= {1'b0, need_r}) begin
        // sequence complete
        if (acc_ext <= u8u16_pkg::BmpMax) begin
          units[0] = acc_ext[15:0];
          n        = 3'd1;
        end else begin
          units[0] = u8u16_pkg::SurrHi | diff[25:10];
          units[1] = u8u16_pkg::SurrLo | {6'b0, acc_ext[9:0]};
          n        = 3'd2;
        end
        acc_nxt  = '0;
        need_nxt = '0;
        seen_nxt = '0;
      end else begin
        if (seen_r < 3'(u8u16_pkg::PendDepth)) begin
          pend_nxt[seen_r] = b[5:0];
        end
        seen_nxt = seen_r + 3'd1;
      end
    end else begin
      // broken sequence: replay buffered continuation bytes
      if (need_r != 3'd0) begin
        for (int i = 0; i < u8u16_pkg::PendDepth; i++) begin
          if (3'(i) < seen_r && n < 3'(u8u16_pkg::MaxUnits)) begin
            units[n] = {8'h00, u8u16_pkg::ContMark | {2'b00, pend_r[i]}};
            n        = n + 3'd1;
          end
        end
        acc_nxt  = '0;
        need_nxt = '0;
        seen_nxt = '0;
      end
      case (b) inside
        8'b110?????: begin
          acc_nxt  = {26'b0, b[4:0]};
          need_nxt = 3'd1;
          seen_nxt = '0;
        end
        8'b1110????: begin
          acc_nxt  = {27'b0, b[3:0]};
          need_nxt = 3'd2;
          seen_nxt = '0;
        end
        8'b11110???: begin
          acc_nxt  = {28'b0, b[2:0]};
          need_nxt = 3'd3;
          seen_nxt = '0;
        end
        8'b111110??: begin
          acc_nxt  = {29'b0, b[1:0]};
          need_nxt = 3'd4;
          seen_nxt = '0;
        end
        8'b1111110?: begin
          acc_nxt  = {30'b0, b[0]};
          need_nxt = 3'd5;
          seen_nxt = '0;
        end
        default: begin
          // ascii, stray continuation, 0xfe, 0xff: byte passes as is
          if (n < 3'(u8u16_pkg::MaxUnits)) begin
            units[n] = {8'h00, b};
            n        = n + 3'd1;
          end
        end
      endcase
    end

    // end of stream: close any open sequence and flush its buffered continuation bytes
    if (in_if.end_of_stream && need_nxt != 3'd0) begin
      for (int i = 0; i < u8u16_pkg::PendDepth; i++) begin
        if (3'(i) < seen_nxt && n < 3'(u8u16_pkg::MaxUnits)) begin
          units[n] = {8'h00, u8u16_pkg::ContMark | {2'b00, pend_nxt[i]}};
          n        = n + 3'd1;
        end
      end
      acc_nxt  = '0;
      need_nxt = '0;
      seen_nxt = '0;
    end
  end

  assign q_push      = xfer && (n != 3'd0);
  assign q_job.units = units;
  assign q_job.count = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      need_r <= '0;
      seen_r <= '0;
    end else if (xfer) begin
      acc_r  <= acc_nxt;
      need_r <= need_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

// ----- rtl/core/u8u16_queue.sv -----
// ----------------------------------------------------------------------------
// u8u16_queue
// Small fifo of unit lists between the front and the back.
// ----------------------------------------------------------------------------
module u8u16_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u8u16_pkg::job_t push_job,
  output logic            can_push,
  input  logic            pop,
  output logic            can_pop,
  output u8u16_pkg::job_t pop_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  u8u16_pkg::job_t     slots [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     cnt_r;
  logic                do_push, do_pop;

  assign can_push = (cnt_r != CntW'(DEPTH));
  assign can_pop  = (cnt_r != '0);
  assign do_push  = push && can_push;
  assign do_pop   = pop && can_pop;
  assign pop_job  = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/u8u16_back.sv -----
// ----------------------------------------------------------------------------
// u8u16_back
// Serializes each unit list onto the output channel, one unit per transfer.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  u8u16_pkg::job_t q_job,
  output logic            q_pop,
  u8u16_out_if.source     out_if
);

  u8u16_pkg::job_t job_r;
  logic            busy_r;
  logic [2:0]      idx_r;
  logic            at_last;
  logic            done;

  assign at_last = (idx_r == job_r.count - 3'd1);
  assign done    = busy_r && out_if.ready && at_last;
  assign q_pop   = q_valid && (!busy_r || done);

  assign out_if.valid     = busy_r;
  assign out_if.unit_out  = job_r.units[idx_r];
  assign out_if.last_unit = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_if.ready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

endmodule
